// File: hw/rtl/pamt_pkg.sv
// Shared types and constants of the paged address map translator.
// No dependencies; every other file imports this package.
package pamt_pkg;

  // fixed field widths of the request and result channels
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 32;
  localparam int RID_IN_W = 4;
  localparam int OWNER_W  = 4;
  localparam int SIDX_W   = 22;

  // request function codes
  localparam logic FUNC_MAP       = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TR_LOOK,
    S_MAP_SETUP,
    S_MAP_WALK,
    S_MAP_DONE
  } pamt_state_t;

  // page table port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pamt_mem_ctl_t;

endpackage

// File: hw/rtl/pamt_if.sv
// Request and result channel interfaces of the paged address map translator.
// Depends on pamt_pkg for field widths.
interface pamt_in_if import pamt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [ADDR_W-1:0]   address;
  logic [RID_IN_W-1:0] region_id;
  logic [SIZE_W-1:0]   region_size;

  modport source (output valid, func, address, region_id, region_size, input ready);
  modport sink   (input valid, func, address, region_id, region_size, output ready);
endinterface

interface pamt_out_if import pamt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fault;
  logic [OWNER_W-1:0] owner_region;
  logic [SIDX_W-1:0]  storage_index;
  logic               overwrote;
  logic               clipped;

  modport source (output valid, fault, owner_region, storage_index, overwrote, clipped,
                  input ready);
  modport sink   (input valid, fault, owner_region, storage_index, overwrote, clipped,
                  output ready);
endinterface

// File: hw/rtl/pamt_page_mem.sv
// Page table memory: one {valid, owner} entry per page, one write and one read port.
// Sweeps every entry invalid after reset. Depends on pamt_pkg.
module pamt_page_mem import pamt_pkg::*; #(
  parameter int PIW = 10,
  parameter int RW  = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pamt_mem_ctl_t ctl,
  input  logic [PIW-1:0] raddr,
  input  logic [PIW-1:0] waddr,
  input  logic [RW:0]    wdata,
  output logic [RW:0]    rdata,
  output logic           clr_busy
);

  localparam int DEPTH = 1 << PIW;

  logic [RW:0]    mem [DEPTH];
  logic [RW:0]    rdata_r;
  logic           clr_busy_r;
  logic [PIW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + PIW'(1);
      if (clr_addr_r == '1) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rdata_r <= mem[raddr];
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: hw/rtl/pamt_ctrl.sv
// Sequencer and datapath: accepts requests, walks the page table one page per cycle
// for maps and does the lookup for translates. Depends on pamt_pkg and pamt_if.
module pamt_ctrl import pamt_pkg::*; #(
  parameter int OW  = 12,
  parameter int PIW = 10,
  parameter int RW  = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  pamt_in_if.sink        in_ch,
  pamt_out_if.source     out_ch,
  output pamt_mem_ctl_t  mem_ctl,
  output logic [PIW-1:0] mem_raddr,
  output logic [PIW-1:0] mem_waddr,
  output logic [RW:0]    mem_wdata,
  input  logic [RW:0]    mem_rdata,
  input  logic           clr_busy
);

  localparam int NREG = 1 << RW;
  localparam int LW   = PIW + OW;
  localparam logic [SIZE_W:0] OFF_MASK = {{(SIZE_W+1-OW){1'b0}}, {OW{1'b1}}};

  pamt_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] addr_r;
  logic [RW-1:0]     rid_r;
  logic [SIZE_W-1:0] size_r;
  logic [PIW-1:0]    region_first_r [NREG];

  logic [PIW-1:0] cur_r, cur_nxt;
  logic [PIW:0]   left_r, left_nxt;
  logic           pend_r, pend_nxt;
  logic [PIW-1:0] pend_addr_r;
  logic           over_r, clip_r;

  logic               out_valid_r;
  logic               out_fault_r;
  logic [OWNER_W-1:0] out_owner_r;
  logic [SIDX_W-1:0]  out_sidx_r;
  logic               out_over_r;
  logic               out_clip_r;

  logic acc, in_ready, out_free, out_load;

  // map setup arithmetic
  logic [PIW-1:0] page_r;
  logic [SIZE_W:0] size_up, count, room;
  logic            clip_calc;
  logic [PIW:0]    n_pages;

  // translate lookup
  logic               pg_valid;
  logic [RW-1:0]      pg_owner;
  logic [PIW-1:0]     first_pg, diff;
  logic [LW-1:0]      lin;
  logic [LW+SIDX_W-1:0] lin_ext;
  logic [RW+OWNER_W-1:0] owner_ext;
  logic               res_fault;
  logic [OWNER_W-1:0] res_owner;
  logic [SIDX_W-1:0]  res_sidx;

  assign page_r    = addr_r[OW +: PIW];
  assign size_up   = {1'b0, size_r} + OFF_MASK;
  assign count     = size_up >> OW;
  assign room      = ((SIZE_W+1)'(1) << PIW) - (SIZE_W+1)'(page_r);
  assign clip_calc = count > room;
  assign n_pages   = clip_calc ? room[PIW:0] : count[PIW:0];

  assign pg_valid  = mem_rdata[RW];
  assign pg_owner  = mem_rdata[RW-1:0];
  assign first_pg  = region_first_r[pg_owner];
  assign diff      = page_r - first_pg;
  assign lin       = {diff, addr_r[OW-1:0]};
  assign lin_ext   = {{SIDX_W{1'b0}}, lin};
  assign owner_ext = {{OWNER_W{1'b0}}, pg_owner};
  assign res_fault = !pg_valid;
  assign res_owner = pg_valid ? owner_ext[OWNER_W-1:0] : '0;
  assign res_sidx  = pg_valid ? lin_ext[SIDX_W-1:0] : '0;

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign acc      = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) state_nxt = (in_ch.func == FUNC_TRANSLATE) ? S_TR_LOOK : S_MAP_SETUP;
      end
      S_TR_LOOK: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_MAP_SETUP: begin
        state_nxt = (size_r == '0) ? S_MAP_DONE : S_MAP_WALK;
      end
      S_MAP_WALK: begin
        if (left_r == '0 && !pend_r) state_nxt = S_MAP_DONE;
      end
      S_MAP_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and walker next values
  always_comb begin
    mem_ctl   = '0;
    mem_raddr = in_ch.address[OW +: PIW];
    mem_waddr = pend_addr_r;
    mem_wdata = {1'b1, rid_r};
    out_load  = 1'b0;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      S_IDLE: begin
        mem_ctl.rd_en = acc && (in_ch.func == FUNC_TRANSLATE);
      end
      S_TR_LOOK: begin
        out_load = out_free;
      end
      S_MAP_SETUP: begin
        cur_nxt  = page_r;
        left_nxt = (size_r == '0) ? '0 : n_pages;
        pend_nxt = 1'b0;
      end
      S_MAP_WALK: begin
        // read page k while page k-1 is checked and written
        mem_raddr     = cur_r;
        mem_ctl.rd_en = (left_r != '0);
        mem_ctl.wr_en = pend_r;
        pend_nxt      = (left_r != '0);
        if (left_r != '0) begin
          cur_nxt  = cur_r + PIW'(1);
          left_nxt = left_r - (PIW+1)'(1);
        end
      end
      S_MAP_DONE: begin
        out_load = out_free;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (state_r == S_MAP_WALK) pend_addr_r <= cur_r;
    if (acc) begin
      addr_r <= in_ch.address;
      rid_r  <= in_ch.region_id[RW-1:0];
      size_r <= in_ch.region_size;
    end
    if (state_r == S_MAP_SETUP) begin
      over_r <= 1'b0;
      clip_r <= (size_r != '0) && clip_calc;
      if (size_r != '0) region_first_r[rid_r] <= page_r;
    end else if (state_r == S_MAP_WALK && pend_r && pg_valid) begin
      over_r <= 1'b1;
    end
    if (out_load) begin
      if (state_r == S_TR_LOOK) begin
        out_fault_r <= res_fault;
        out_owner_r <= res_owner;
        out_sidx_r  <= res_sidx;
        out_over_r  <= 1'b0;
        out_clip_r  <= 1'b0;
      end else begin
        out_fault_r <= 1'b0;
        out_owner_r <= '0;
        out_sidx_r  <= '0;
        out_over_r  <= over_r;
        out_clip_r  <= clip_r;
      end
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.fault         = out_fault_r;
  assign out_ch.owner_region  = out_owner_r;
  assign out_ch.storage_index = out_sidx_r;
  assign out_ch.overwrote     = out_over_r;
  assign out_ch.clipped       = out_clip_r;

  a_tr_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.func == FUNC_TRANSLATE) |=> (state_r == S_TR_LOOK))
    else $error("translate request did not go to lookup");

  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_busy && mem_ctl.wr_en))
    else $error("table write during clearing pass");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP_WALK && left_r != '0) |=> (left_r == $past(left_r) - (PIW+1)'(1)))
    else $error("page walk count did not step");

  a_done_retired: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP_DONE) |-> !pend_r)
    else $error("map reported with a page write pending");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_clip_r || out_over_r)) |-> !out_fault_r)
    else $error("map flags on a translate result");

endmodule

// File: hw/rtl/paged_address_map_translate.sv
// A translate goes through accept with the table read, then lookup into the result register.
// A map goes through accept, setup, the walk of one page per cycle, one write drain step,
// one closing walk step and report; a zero-size map goes through accept, setup and report.
// One request at a time: a new one is accepted only in idle; the page walk sets map time.
// Reset (synchronous, rst_n low) starts a clearing pass over every page table entry;
// no request is accepted until it ends. Results wait in an output register.
module paged_address_map_translate import pamt_pkg::*; #(
  parameter int OFFSET_WIDTH     = 12,
  parameter int PAGE_INDEX_WIDTH = 10,
  parameter int REGION_ID_WIDTH  = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  pamt_in_if.sink    in_ch,
  pamt_out_if.source out_ch
);

  // only the low bits of the region id field take part
  localparam int RW = (REGION_ID_WIDTH < RID_IN_W) ? REGION_ID_WIDTH : RID_IN_W;

  pamt_mem_ctl_t               mem_ctl;
  logic [PAGE_INDEX_WIDTH-1:0] mem_raddr;
  logic [PAGE_INDEX_WIDTH-1:0] mem_waddr;
  logic [RW:0]                 mem_wdata;
  logic [RW:0]                 mem_rdata;
  logic                        clr_busy;

  pamt_ctrl #(
    .OW  (OFFSET_WIDTH),
    .PIW (PAGE_INDEX_WIDTH),
    .RW  (RW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_ctl   (mem_ctl),
    .mem_raddr (mem_raddr),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .clr_busy  (clr_busy)
  );

  pamt_page_mem #(
    .PIW (PAGE_INDEX_WIDTH),
    .RW  (RW)
  ) u_page_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .raddr    (mem_raddr),
    .waddr    (mem_waddr),
    .wdata    (mem_wdata),
    .rdata    (mem_rdata),
    .clr_busy (clr_busy)
  );

endmodule
